// ===== rtl/order_statistic_multiset_core_assert.svh =====
// Assertion macros for the order statistic multiset core
`ifndef ORDER_STATISTIC_MULTISET_CORE_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_CORE_ASSERT_SVH

// same-cycle implication
`define OSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("osm assertion failed");

// next-cycle implication
`define OSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("osm assertion failed");

`endif

// ===== rtl/osm_pkg.sv =====
// ----------------------------------------------------------------------------
// osm_pkg
// Types and constants shared by the order statistic multiset core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package osm_pkg;

  localparam int KEY_W  = 32;
  localparam int CNT_W  = 20;
  localparam int RANK_W = CNT_W + 1;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_RANK   = 3'd2;
  localparam logic [2:0] OP_SELECT = 3'd3;
  localparam logic [2:0] OP_PRED   = 3'd4;
  localparam logic [2:0] OP_SUCC   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_INC  = 3'd1;
  localparam logic [2:0] ACT_NEW  = 3'd2;
  localparam logic [2:0] ACT_DEC  = 3'd3;
  localparam logic [2:0] ACT_DEL  = 3'd4;

  localparam logic [CNT_W-1:0] TOTAL_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [KEY_W-1:0] key;
    logic [CNT_W-1:0]        position;
  } osm_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] result_key;
    logic [RANK_W-1:0]       result_rank;
    logic [1:0]              status;
  } osm_out_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_ev;
    logic sh_init;
    logic sh_rd;
    logic sh_wr;
    logic wr_new;
    logic wr_cnt;
    logic del_done;
    logic latch_res;
    logic emit;
  } osm_cmd_t;

  typedef struct packed {
    logic       scan_done;
    logic       sh_done;
    logic [2:0] act;
  } osm_sts_t;

endpackage

// ===== rtl/osm_dp.sv =====
// ----------------------------------------------------------------------------
// osm_dp
// Datapath: sorted key/count tables, scan accumulators, shift and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module osm_dp import osm_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  osm_cmd_t cmd,
  output osm_sts_t sts,
  input  osm_in_t  in_data,
  output logic     out_valid,
  output osm_out_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [CNT_W-1:0] cnt_mem [CAPACITY];
  logic [KEY_W-1:0] rd_key_r;
  logic [CNT_W-1:0] rd_cnt_r;

  logic [2:0]              op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        want_r;
  logic [CW-1:0]           idx_r, lidx_r, sh_r, used_r;
  logic [CNT_W-1:0]        total_r, sum_less_r, hit_cnt_r;
  logic [CNT_W:0]          sel_sum_r;
  logic signed [KEY_W-1:0] prev_key_r, succ_key_r, sel_key_r;
  logic                    succ_found_r, sel_found_r, hit_r;
  osm_out_t                res_r, out_data_r;
  logic                    out_valid_r;

  logic [CW-1:0]    raddr;
  logic             we;
  logic [CW-1:0]    waddr;
  logic [KEY_W-1:0] wkey;
  logic [CNT_W-1:0] wcnt;
  logic [CNT_W:0]   sel_sum_nxt;
  logic [2:0]       act;
  osm_out_t         res_nxt;
  logic             is_ins;

  assign is_ins = (op_r == OP_INSERT);

  always_comb begin
    raddr = '0;
    if (cmd.scan_rd) begin
      raddr = idx_r;
    end else if (cmd.sh_rd) begin
      raddr = is_ins ? sh_r - CW'(1) : sh_r + CW'(1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = sh_r;
    wkey  = rd_key_r;
    wcnt  = rd_cnt_r;
    if (cmd.sh_wr) begin
      we = 1'b1;
    end else if (cmd.wr_new) begin
      we    = 1'b1;
      waddr = lidx_r;
      wkey  = key_r;
      wcnt  = CNT_W'(1);
    end else if (cmd.wr_cnt) begin
      we    = 1'b1;
      waddr = lidx_r;
      wkey  = key_r;
      wcnt  = is_ins ? hit_cnt_r + CNT_W'(1) : hit_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr[IDX_W-1:0]] <= wkey;
      cnt_mem[waddr[IDX_W-1:0]] <= wcnt;
    end
    rd_key_r <= key_mem[raddr[IDX_W-1:0]];
    rd_cnt_r <= cnt_mem[raddr[IDX_W-1:0]];
  end

  assign sel_sum_nxt = sel_sum_r + {1'b0, rd_cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      total_r <= '0;
    end else if (cmd.wr_new) begin
      used_r  <= used_r + CW'(1);
      total_r <= total_r + CNT_W'(1);
    end else if (cmd.del_done) begin
      used_r  <= used_r - CW'(1);
      total_r <= total_r - CNT_W'(1);
    end else if (cmd.wr_cnt) begin
      total_r <= is_ins ? total_r + CNT_W'(1) : total_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= in_data.opcode;
      key_r        <= in_data.key;
      want_r       <= (in_data.position == '0) ? CNT_W'(1) : in_data.position;
      idx_r        <= '0;
      lidx_r       <= '0;
      sum_less_r   <= '0;
      sel_sum_r    <= '0;
      hit_r        <= 1'b0;
      hit_cnt_r    <= '0;
      succ_found_r <= 1'b0;
      sel_found_r  <= 1'b0;
      prev_key_r   <= '0;
      succ_key_r   <= '0;
      sel_key_r    <= '0;
    end else if (cmd.scan_ev) begin
      idx_r     <= idx_r + CW'(1);
      sel_sum_r <= sel_sum_nxt;
      if ($signed(rd_key_r) < key_r) begin
        lidx_r     <= lidx_r + CW'(1);
        sum_less_r <= sum_less_r + rd_cnt_r;
        prev_key_r <= rd_key_r;
      end else if ($signed(rd_key_r) == key_r) begin
        hit_r     <= 1'b1;
        hit_cnt_r <= rd_cnt_r;
      end else if (!succ_found_r) begin
        succ_found_r <= 1'b1;
        succ_key_r   <= rd_key_r;
      end
      if (!sel_found_r && sel_sum_nxt >= {1'b0, want_r}) begin
        sel_found_r <= 1'b1;
        sel_key_r   <= rd_key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sh_init) begin
      sh_r <= is_ins ? used_r : lidx_r;
    end else if (cmd.sh_wr) begin
      sh_r <= is_ins ? sh_r - CW'(1) : sh_r + CW'(1);
    end
  end

  always_comb begin
    act = ACT_NONE;
    if (is_ins) begin
      if (total_r == TOTAL_MAX) begin
        act = ACT_NONE;
      end else if (hit_r) begin
        act = ACT_INC;
      end else if (used_r != CAP_C) begin
        act = ACT_NEW;
      end
    end else if (op_r == OP_REMOVE && hit_r) begin
      act = (hit_cnt_r == CNT_W'(1)) ? ACT_DEL : ACT_DEC;
    end
  end

  always_comb begin
    res_nxt = '0;
    case (op_r)
      OP_INSERT: begin
        if (act == ACT_NONE) res_nxt.status = ST_FULL;
      end
      OP_REMOVE: begin
        if (!hit_r) res_nxt.status = ST_NONE;
      end
      OP_RANK: begin
        res_nxt.result_rank = {1'b0, sum_less_r} + RANK_W'(1);
      end
      OP_SELECT: begin
        if (want_r > total_r) res_nxt.status = ST_NONE;
        else res_nxt.result_key = sel_key_r;
      end
      OP_PRED: begin
        if (lidx_r == '0) res_nxt.status = ST_NONE;
        else res_nxt.result_key = prev_key_r;
      end
      OP_SUCC: begin
        if (!succ_found_r) res_nxt.status = ST_NONE;
        else res_nxt.result_key = succ_key_r;
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_res) res_r <= res_nxt;
    if (cmd.emit) out_data_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign sts.scan_done = (idx_r == used_r);
  assign sts.sh_done   = is_ins ? (sh_r == lidx_r)
                                : (({1'b0, sh_r} + (CW + 1)'(1)) >= {1'b0, used_r});
  assign sts.act       = act;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

// ===== rtl/osm_ctrl.sv =====
// ----------------------------------------------------------------------------
// osm_ctrl
// Controller: sequences scan, decision, shift and write-back per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module osm_ctrl import osm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  osm_sts_t sts,
  output osm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRD   = 3'd1;
  localparam logic [2:0] S_SEV   = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_SHRD  = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.scan_done) begin
          state_nxt = S_DEC;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SEV;
        end
      end
      S_SEV: begin
        cmd.scan_ev = 1'b1;
        state_nxt   = S_SRD;
      end
      S_DEC: begin
        cmd.sh_init   = 1'b1;
        cmd.latch_res = 1'b1;
        case (sts.act) inside
          ACT_NEW, ACT_DEL: state_nxt = S_SHRD;
          ACT_INC, ACT_DEC: state_nxt = S_WRITE;
          default:          state_nxt = S_DONE;
        endcase
      end
      S_SHRD: begin
        if (sts.sh_done) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHRD;
      end
      S_WRITE: begin
        case (sts.act) inside
          ACT_NEW:          cmd.wr_new   = 1'b1;
          ACT_DEL:          cmd.del_done = 1'b1;
          ACT_INC, ACT_DEC: cmd.wr_cnt   = 1'b1;
          default:          cmd.wr_cnt   = 1'b0;
        endcase
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/order_statistic_multiset_core.sv =====
// Timing: queries scan all U stored entries before the result; insert and remove may
// also shift entries, where U is the number of distinct keys stored.
// Throughput: one request at a time; busy drops in the result strobe cycle, where the
// next request may be accepted. The read and evaluate states of each entry set the rate.
// Reset: synchronous active-low rst_n empties the set; no clearing pass is needed.
// ----------------------------------------------------------------------------
// order_statistic_multiset_core
// Ordered multiset of signed keys with rank, select, predecessor, successor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module order_statistic_multiset_core import osm_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  osm_in_t  in_data,
  output logic     out_valid,
  output osm_out_t out_data
);

  osm_cmd_t cmd;
  osm_sts_t sts;

  osm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  osm_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/osm_checker.sv =====
// ----------------------------------------------------------------------------
// osm_port_checker
// Port-level checks of the order statistic multiset core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "order_statistic_multiset_core_assert.svh"
module osm_port_checker import osm_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input osm_out_t out_data
);

  `OSM_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  `OSM_ASSERT_NOW(a_idle_on_result, out_valid, !busy)
  `OSM_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `OSM_ASSERT_NOW(a_status_code, out_valid, out_data.status != 2'd3)
  `OSM_ASSERT_NOW(a_rank_only_ok, out_valid && out_data.result_rank != '0,
                  out_data.status == ST_OK && out_data.result_key == '0)

endmodule

bind order_statistic_multiset_core osm_port_checker u_osm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
